>>> hdl/half_open_interval_set_macros.svh
// Assertion macros for the interval set block.
// Used by half_open_interval_set.sv; no other dependencies.
`ifndef HALF_OPEN_INTERVAL_SET_MACROS_SVH
`define HALF_OPEN_INTERVAL_SET_MACROS_SVH

`ifndef SYNTHESIS
`define HOIS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define HOIS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define HOIS_ASSERT(lbl, prop, msg)
`define HOIS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> hdl/hois_pkg.sv
// Shared types and codes for the interval set block.
// No dependencies.
package hois_pkg;

   localparam int COORD_BITS = 32;

   typedef logic [COORD_BITS-1:0] coord_type;

   // request kinds
   localparam logic [1:0] REQ_ADD    = 2'd0;
   localparam logic [1:0] REQ_REMOVE = 2'd1;
   localparam logic [1:0] REQ_QUERY  = 2'd2;
   localparam logic [1:0] REQ_NONE   = 2'd3;

   // response status codes
   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic [1:0] req_type;
      coord_type  left;
      coord_type  right;
   } req_word_type;

   typedef struct packed {
      logic       covered;
      logic [1:0] status;
      logic [6:0] entries_used;
   } rsp_word_type;

   typedef struct packed {
      coord_type lo;
      coord_type hi;
   } interval_type;

   typedef struct packed {
      logic pop;   // shift toward cell 0
      logic load;  // take the push word
   } cell_ctl_type;

   typedef enum logic [1:0] {
      CS_IDLE,
      CS_SCAN,
      CS_BUILD,
      CS_DONE
   } ctrl_state_type;

endpackage

>>> hdl/half_open_interval_set.sv
// Interval set: sorted disjoint [lo,hi) table held in a chain of entry cells.
// One word in flight; the next word is taken once the response is registered.
// Both passes walk the chain one cell per cycle through the head cell, except that
// the rebuild pass holds the walk while it pushes a pending word.
// Reset (synchronous, active high) empties the table and idles the sequencer.
`include "half_open_interval_set_macros.svh"
module half_open_interval_set
   import hois_pkg::*;
#(
   parameter int MAX_INTERVALS = 64
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_data
);

   localparam int IDX_W = $clog2(MAX_INTERVALS);

   // chain contents; cell 0 is the head the sequencer reads
   interval_type             cell_q [MAX_INTERVALS];
   logic [MAX_INTERVALS-1:0] load_vec;
   logic                     pop;
   logic                     push;
   logic [IDX_W-1:0]         wpos;
   interval_type             push_data;

   hois_ctrl #(
      .MAX_INTERVALS(MAX_INTERVALS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .head      (cell_q[0]),
      .pop       (pop),
      .push      (push),
      .wpos      (wpos),
      .push_data (push_data)
   );

   // each cell shifts from its right neighbor on pop, or takes the push
   // word when it is the tail slot
   for (genvar i = 0; i < MAX_INTERVALS; i++) begin : g_cell
      cell_ctl_type ctl;
      assign load_vec[i] = push && (wpos == IDX_W'(i));
      assign ctl.pop     = pop;
      assign ctl.load    = load_vec[i];
      hois_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .shift_data (cell_q[(i + 1 < MAX_INTERVALS) ? i + 1 : i]),
         .load_data  (push_data),
         .cell_data  (cell_q[i])
      );
   end

   // a push lands in exactly one cell
   `HOIS_ASSERT(a_push_onehot, (push |-> $onehot(load_vec)), "push hit no single cell")
   // the chain only moves while a word is being worked on
   `HOIS_ASSERT(a_pop_busy, (pop |-> req_stall), "chain moved while idle")
   // an accepted word makes the block busy in the next cycle
   `HOIS_ASSERT_NEXT(a_accept_busy, (req_valid && !req_stall), req_stall, "not busy after accept")

endmodule

>>> hdl/hois_cell.sv
// One table entry of the interval chain.
// Depends on hois_pkg.
module hois_cell
   import hois_pkg::*;
(
   input  logic         clock,
   input  cell_ctl_type ctl,
   input  interval_type shift_data,
   input  interval_type load_data,
   output interval_type cell_data
);

   interval_type data_ff;
   interval_type data_in;

   always_comb begin
      data_in = data_ff;
      if (ctl.load) begin
         data_in = load_data;
      end else if (ctl.pop) begin
         data_in = shift_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign cell_data = data_ff;

endmodule

>>> hdl/hois_ctrl.sv
// Sequencer for the interval chain: scan pass, rebuild pass, response register.
// Depends on hois_pkg.
module hois_ctrl
   import hois_pkg::*;
#(
   parameter int MAX_INTERVALS = 64
)
(
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  req_word_type                     req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output rsp_word_type                     rsp_data,
   input  interval_type                     head,
   output logic                             pop,
   output logic                             push,
   output logic [$clog2(MAX_INTERVALS)-1:0] wpos,
   output interval_type                     push_data
);

   localparam int CNT_W = $clog2(MAX_INTERVALS + 1);
   localparam int IDX_W = $clog2(MAX_INTERVALS);
   localparam int N_W   = $clog2(MAX_INTERVALS + 3);

   ctrl_state_type state_ff, state_in;
   logic [1:0]     kind_ff, kind_in;
   coord_type      l_ff, l_in, r_ff, r_in;
   coord_type      ml_ff, ml_in, mr_ff, mr_in;
   logic [CNT_W-1:0] occ_ff, occ_in, rem_ff, rem_in;
   logic [N_W-1:0] n_ff, n_in;
   logic           cov_ff, cov_in;
   logic           placed_ff, placed_in;
   logic           pend_vld_ff, pend_vld_in;
   interval_type   pend_ff, pend_in;
   logic [1:0]     status_ff, status_in;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_word_type   rsp_ff, rsp_in;

   always_comb begin
      logic [CNT_W-1:0] pos;
      logic             cut_lo;
      logic             cut_hi;
      state_in    = state_ff;
      kind_in     = kind_ff;
      l_in        = l_ff;
      r_in        = r_ff;
      ml_in       = ml_ff;
      mr_in       = mr_ff;
      occ_in      = occ_ff;
      rem_in      = rem_ff;
      n_in        = n_ff;
      cov_in      = cov_ff;
      placed_in   = placed_ff;
      pend_vld_in = pend_vld_ff;
      pend_in     = pend_ff;
      status_in   = status_ff;
      rsp_in      = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      pop         = 1'b0;
      push        = 1'b0;
      push_data   = head;
      cut_lo      = head.lo < l_ff;
      cut_hi      = head.hi > r_ff;
      case (state_ff)
         CS_IDLE: begin
            if (req_valid) begin
               kind_in = req_data.req_type;
               l_in    = req_data.left;
               r_in    = req_data.right;
               ml_in   = req_data.left;
               mr_in   = req_data.right;
               cov_in  = 1'b0;
               rem_in  = occ_ff;
               n_in    = (req_data.req_type == REQ_ADD) ? N_W'(1) : '0;
               if (req_data.left >= req_data.right) begin
                  status_in = ST_EMPTY;
                  state_in  = CS_DONE;
               end else if (req_data.req_type == REQ_NONE) begin
                  status_in = ST_DONE;
                  state_in  = CS_DONE;
               end else begin
                  state_in = CS_SCAN;
               end
            end
         end
         CS_SCAN: begin
            if (rem_ff != '0) begin
               // rotate: head goes back in at the tail
               pop    = 1'b1;
               push   = 1'b1;
               rem_in = rem_ff - CNT_W'(1);
               case (kind_ff)
                  REQ_ADD: begin
                     if (head.hi >= l_ff && head.lo <= r_ff) begin
                        if (head.lo < ml_ff) ml_in = head.lo;
                        if (head.hi > mr_ff) mr_in = head.hi;
                     end else begin
                        n_in = n_ff + N_W'(1);
                     end
                  end
                  REQ_REMOVE: begin
                     if (head.hi <= l_ff || head.lo >= r_ff) begin
                        n_in = n_ff + N_W'(1);
                     end else begin
                        n_in = n_ff + N_W'(cut_lo) + N_W'(cut_hi);
                     end
                  end
                  default: begin
                     if (head.lo <= l_ff && r_ff <= head.hi) cov_in = 1'b1;
                  end
               endcase
            end else if (kind_ff == REQ_QUERY) begin
               status_in = ST_DONE;
               state_in  = CS_DONE;
            end else if (n_ff > N_W'(MAX_INTERVALS)) begin
               status_in = ST_FULL;
               state_in  = CS_DONE;
            end else begin
               rem_in      = occ_ff;
               placed_in   = 1'b0;
               pend_vld_in = 1'b0;
               state_in    = CS_BUILD;
            end
         end
         CS_BUILD: begin
            if (pend_vld_ff) begin
               push        = 1'b1;
               push_data   = pend_ff;
               pend_vld_in = 1'b0;
            end else if (rem_ff != '0) begin
               pop    = 1'b1;
               rem_in = rem_ff - CNT_W'(1);
               if (kind_ff == REQ_ADD) begin
                  if (head.hi < l_ff) begin
                     push = 1'b1;
                  end else if (head.lo > r_ff) begin
                     push = 1'b1;
                     if (!placed_ff) begin
                        push_data   = '{lo: ml_ff, hi: mr_ff};
                        placed_in   = 1'b1;
                        pend_vld_in = 1'b1;
                        pend_in     = head;
                     end
                  end
               end else begin
                  if (head.hi <= l_ff || head.lo >= r_ff) begin
                     push = 1'b1;
                  end else if (cut_lo) begin
                     push      = 1'b1;
                     push_data = '{lo: head.lo, hi: l_ff};
                     if (cut_hi) begin
                        pend_vld_in = 1'b1;
                        pend_in     = '{lo: r_ff, hi: head.hi};
                     end
                  end else if (cut_hi) begin
                     push      = 1'b1;
                     push_data = '{lo: r_ff, hi: head.hi};
                  end
               end
            end else if (kind_ff == REQ_ADD && !placed_ff) begin
               push      = 1'b1;
               push_data = '{lo: ml_ff, hi: mr_ff};
               placed_in = 1'b1;
            end else begin
               status_in = ST_DONE;
               state_in  = CS_DONE;
            end
         end
         CS_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in.covered      = cov_ff;
               rsp_in.status       = status_ff;
               rsp_in.entries_used = 7'(occ_ff);
               rsp_valid_in        = 1'b1;
               state_in            = CS_IDLE;
            end
         end
         default: begin
            state_in = CS_IDLE;
         end
      endcase
      // occupancy tracking and tail position
      if (push && !pop) begin
         pos    = occ_ff;
         occ_in = occ_ff + CNT_W'(1);
      end else begin
         pos = occ_ff - CNT_W'(1);
         if (pop && !push) occ_in = occ_ff - CNT_W'(1);
      end
      wpos = IDX_W'(pos);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CS_IDLE;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         pend_vld_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_vld_ff  <= pend_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      l_ff      <= l_in;
      r_ff      <= r_in;
      ml_ff     <= ml_in;
      mr_ff     <= mr_in;
      rem_ff    <= rem_in;
      n_ff      <= n_in;
      cov_ff    <= cov_in;
      placed_ff <= placed_in;
      pend_ff   <= pend_in;
      status_ff <= status_in;
      rsp_ff    <= rsp_in;
   end

   assign req_stall = (state_ff != CS_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
